@@ hw/rtl/mi3_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the 3x3 matrix inverse pipeline
// no dependencies
package mi3_pkg;

    localparam int ELEMENT_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF     = 8;
    localparam int N_ELEM            = 9;
    localparam int OUT_W             = 32;
    localparam int OUT_FRAC          = 16;

    // element indexes p, q, r, s of each cofactor p*q - r*s, row order
    localparam int COF_IDX [N_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    localparam logic [OUT_W-1:0] POS_LIM = 32'h7FFF_FFFF;
    localparam logic [OUT_W-1:0] NEG_LIM = 32'h8000_0000;

    typedef struct packed {
        logic              zero;
        logic [N_ELEM-1:0] neg;
        logic [N_ELEM-1:0] ovf;
    } t_flags;

endpackage

@@ hw/rtl/matrix_inverse_3x3.sv @@
`timescale 1ns / 1ps
// 3x3 matrix inverse by adjugate over determinant, fully pipelined
// depends on mi3_pkg, mi3_adj, mi3_det, mi3_div_stage
//
// Accepts one matrix every cycle when the output side keeps up: two stages
// form the cofactors and the adjugate, four form the determinant, magnitudes
// and range check, 32 divider stages each settle one quotient bit for all nine
// elements, and one output stage applies sign, saturation and the singular
// case. Any stall on the output holds items in place; empty stages still fill,
// so the input keeps taking items until the pipeline is full.
module matrix_inverse_3x3 #(
    parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH_DEF,
    parameter int FRAC_BITS     = mi3_pkg::FRAC_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // m11, m12, m13, m21, m22, m23, m31, m32, m33, then zero fill
    input  logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]  i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // inv11, inv12, inv13, inv21, inv22, inv23, inv31, inv32, inv33
    output logic [9*mi3_pkg::OUT_W-1:0]           o_m_tdata,
    // singular, saturated
    output logic [1:0]                            o_m_tuser
);
    import mi3_pkg::*;

    localparam int EW   = ELEMENT_WIDTH;
    localparam int AMW  = 2 * EW;
    localparam int DMW  = 3 * EW + 1;
    localparam int NW   = AMW + FRAC_BITS + OUT_FRAC;
    localparam int CW   = (NW > DMW + OUT_W) ? NW : DMW + OUT_W;

    logic [N_ELEM-1:0][EW-1:0]  in_m;
    logic                       adj_vld, adj_rdy, det_rdy;
    logic [2:0][EW-1:0]         adj_row1;
    logic [N_ELEM-1:0][2*EW:0]  adj_val;

    logic [OUT_W:0]                         vld_c, rdy_c;
    t_flags                                 flags_c [OUT_W+1];
    logic [N_ELEM-1:0][CW-1:0]              rem_c   [OUT_W+1];
    logic [N_ELEM-1:0][OUT_W-1:0]           q_c     [OUT_W+1];
    logic [DMW-1:0]                         dmag_c  [OUT_W+1];

    logic                          r_vld, en_o;
    logic [9*OUT_W-1:0]            r_tdata, n_tdata;
    logic [1:0]                    r_tuser, n_tuser;
    t_flags                        fin;
    logic [N_ELEM-1:0][OUT_W-1:0]  fin_q;
    logic [OUT_W-1:0]              lim, mag;
    logic                          big, any_sat;

    always_comb begin
        for (int j = 0; j < N_ELEM; j++) begin
            in_m[j] = i_s_tdata[j*EW +: EW];
        end
    end

    mi3_adj #(.EW(EW)) u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_m     (in_m),
        .i_rdy   (det_rdy),
        .o_vld   (adj_vld),
        .o_row1  (adj_row1),
        .o_adj   (adj_val)
    );

    mi3_det #(.EW(EW), .FB(FRAC_BITS), .CW(CW), .DMW(DMW)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (adj_vld),
        .o_rdy   (det_rdy),
        .i_row1  (adj_row1),
        .i_adj   (adj_val),
        .i_rdy   (rdy_c[0]),
        .o_vld   (vld_c[0]),
        .o_flags (flags_c[0]),
        .o_num   (rem_c[0]),
        .o_dmag  (dmag_c[0])
    );

    assign adj_rdy  = det_rdy;
    assign q_c[0]   = '0;

    // stage k settles quotient bit OUT_W-1-k
    for (genvar k = 0; k < OUT_W; k++) begin : g_div
        mi3_div_stage #(.CW(CW), .DMW(DMW), .BIT(OUT_W - 1 - k)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (vld_c[k]),
            .o_rdy   (rdy_c[k]),
            .i_flags (flags_c[k]),
            .i_rem   (rem_c[k]),
            .i_q     (q_c[k]),
            .i_dmag  (dmag_c[k]),
            .i_rdy   (rdy_c[k+1]),
            .o_vld   (vld_c[k+1]),
            .o_flags (flags_c[k+1]),
            .o_rem   (rem_c[k+1]),
            .o_q     (q_c[k+1]),
            .o_dmag  (dmag_c[k+1])
        );
    end

    assign en_o         = !r_vld || i_m_tready;
    assign rdy_c[OUT_W] = en_o;
    assign fin          = flags_c[OUT_W];
    assign fin_q        = q_c[OUT_W];

    always_comb begin
        any_sat = 1'b0;
        lim     = '0;
        mag     = '0;
        big     = 1'b0;
        n_tdata = '0;
        for (int j = 0; j < N_ELEM; j++) begin
            lim = fin.neg[j] ? NEG_LIM : POS_LIM;
            big = fin.ovf[j] || (fin_q[j] > lim);
            mag = big ? lim : fin_q[j];
            if (!fin.zero) begin
                n_tdata[j*OUT_W +: OUT_W] = fin.neg[j] ? OUT_W'(-mag) : mag;
                any_sat = any_sat | big;
            end
        end
        n_tuser = {any_sat, fin.zero};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en_o) begin
            r_vld <= vld_c[OUT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_tdata <= n_tdata;
            r_tuser <= n_tuser;
        end
    end

    assign o_m_tvalid = r_vld;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> !(r_tuser[0] && r_tuser[1]))
        else $error("singular and saturated both set");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_tuser[0]) |-> (r_tdata == '0))
        else $error("singular item carries nonzero data");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_vld && !i_m_tready))
        else $error("input stalled without an output stall");

    a_adj_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adj_vld && !adj_rdy) |=> adj_vld)
        else $error("adjugate item dropped while stalled");

endmodule

@@ hw/rtl/mi3_adj.sv @@
`timescale 1ns / 1ps
// cofactor products and adjugate, two register stages
// depends on mi3_pkg
module mi3_adj #(
    parameter int EW = mi3_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    output logic                               o_rdy,
    input  logic [mi3_pkg::N_ELEM-1:0][EW-1:0] i_m,
    input  logic                               i_rdy,
    output logic                               o_vld,
    output logic [2:0][EW-1:0]                 o_row1,
    output logic [mi3_pkg::N_ELEM-1:0][2*EW:0] o_adj
);
    import mi3_pkg::*;

    localparam int PW = 2 * EW;
    localparam int AW = 2 * EW + 1;

    logic                        r_vld_a, r_vld_b;
    logic                        en_a, en_b;
    logic [N_ELEM-1:0][PW-1:0]   r_p, r_q, n_p, n_q;
    logic [2:0][EW-1:0]          r_row1_a, r_row1_b;
    logic [N_ELEM-1:0][AW-1:0]   r_adj, n_adj;

    assign en_b  = !r_vld_b || i_rdy;
    assign en_a  = !r_vld_a || en_b;
    assign o_rdy = en_a;

    always_comb begin
        for (int j = 0; j < N_ELEM; j++) begin
            n_p[j] = PW'($signed(i_m[COF_IDX[j][0]])) * PW'($signed(i_m[COF_IDX[j][1]]));
            n_q[j] = PW'($signed(i_m[COF_IDX[j][2]])) * PW'($signed(i_m[COF_IDX[j][3]]));
        end
    end

    always_comb begin
        for (int j = 0; j < N_ELEM; j++) begin
            n_adj[j] = AW'($signed(r_p[j])) - AW'($signed(r_q[j]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (en_a) begin
                r_vld_a <= i_vld;
            end
            if (en_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_p      <= n_p;
            r_q      <= n_q;
            r_row1_a <= i_m[2:0];
        end
        if (en_b) begin
            r_adj    <= n_adj;
            r_row1_b <= r_row1_a;
        end
    end

    assign o_vld  = r_vld_b;
    assign o_row1 = r_row1_b;
    assign o_adj  = r_adj;

endmodule

@@ hw/rtl/mi3_det.sv @@
`timescale 1ns / 1ps
// determinant, magnitudes, signs and range check ahead of the divider
// depends on mi3_pkg
module mi3_det #(
    parameter int EW = mi3_pkg::ELEMENT_WIDTH_DEF,
    parameter int FB = mi3_pkg::FRAC_BITS_DEF,
    parameter int CW = 81,
    parameter int DMW = 49
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_vld,
    output logic                               o_rdy,
    input  logic [2:0][EW-1:0]                 i_row1,
    input  logic [mi3_pkg::N_ELEM-1:0][2*EW:0] i_adj,
    input  logic                               i_rdy,
    output logic                               o_vld,
    output mi3_pkg::t_flags                    o_flags,
    output logic [mi3_pkg::N_ELEM-1:0][CW-1:0] o_num,
    output logic [DMW-1:0]                     o_dmag
);
    import mi3_pkg::*;

    localparam int AW  = 2 * EW + 1;
    localparam int AMW = 2 * EW;
    localparam int DW  = 3 * EW + 2;
    localparam int SH  = FB + OUT_FRAC;

    logic                      r_vld_c, r_vld_d, r_vld_e, r_vld_f;
    logic                      en_c, en_d, en_e, en_f;
    logic [2:0][DW-1:0]        r_t, n_t;
    logic [N_ELEM-1:0][AW-1:0] r_adj_c, r_adj_d;
    logic [DW-1:0]             r_det;
    logic                      r_zero_e, r_zero_f;
    logic [N_ELEM-1:0]         r_neg_e, r_neg_f, n_neg, r_ovf, n_ovf;
    logic [DMW-1:0]            r_dmag_e, r_dmag_f, n_dmag;
    logic [N_ELEM-1:0][AMW-1:0] r_amag, n_amag;
    logic [N_ELEM-1:0][CW-1:0] r_num, n_num;

    assign en_f  = !r_vld_f || i_rdy;
    assign en_e  = !r_vld_e || en_f;
    assign en_d  = !r_vld_d || en_e;
    assign en_c  = !r_vld_c || en_d;
    assign o_rdy = en_c;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = DW'($signed(i_row1[i])) * DW'($signed(i_adj[3*i]));
        end
    end

    always_comb begin
        n_dmag = r_det[DW-1] ? DMW'(-$signed(r_det)) : DMW'(r_det);
        for (int j = 0; j < N_ELEM; j++) begin
            n_neg[j]  = r_adj_d[j][AW-1] ^ r_det[DW-1];
            n_amag[j] = r_adj_d[j][AW-1] ? AMW'(-$signed(r_adj_d[j])) : AMW'(r_adj_d[j]);
        end
    end

    // a quotient of 2^32 or more can only saturate
    always_comb begin
        for (int j = 0; j < N_ELEM; j++) begin
            n_num[j] = CW'(r_amag[j]) << SH;
            n_ovf[j] = n_num[j] >= (CW'(r_dmag_e) << OUT_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
            r_vld_f <= 1'b0;
        end else begin
            if (en_c) r_vld_c <= i_vld;
            if (en_d) r_vld_d <= r_vld_c;
            if (en_e) r_vld_e <= r_vld_d;
            if (en_f) r_vld_f <= r_vld_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_t     <= n_t;
            r_adj_c <= i_adj;
        end
        if (en_d) begin
            r_det   <= DW'($signed(r_t[0]) + $signed(r_t[1]) + $signed(r_t[2]));
            r_adj_d <= r_adj_c;
        end
        if (en_e) begin
            r_zero_e <= (r_det == '0);
            r_neg_e  <= n_neg;
            r_dmag_e <= n_dmag;
            r_amag   <= n_amag;
        end
        if (en_f) begin
            r_zero_f <= r_zero_e;
            r_neg_f  <= r_neg_e;
            r_dmag_f <= r_dmag_e;
            r_num    <= n_num;
            r_ovf    <= n_ovf;
        end
    end

    assign o_vld         = r_vld_f;
    assign o_flags.zero  = r_zero_f;
    assign o_flags.neg   = r_neg_f;
    assign o_flags.ovf   = r_ovf;
    assign o_num         = r_num;
    assign o_dmag        = r_dmag_f;

endmodule

@@ hw/rtl/mi3_div_stage.sv @@
`timescale 1ns / 1ps
// one restoring-division step for all nine lanes, one quotient bit
// depends on mi3_pkg
module mi3_div_stage #(
    parameter int CW  = 81,
    parameter int DMW = 49,
    parameter int BIT = 31
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_vld,
    output logic                                           o_rdy,
    input  mi3_pkg::t_flags                                i_flags,
    input  logic [mi3_pkg::N_ELEM-1:0][CW-1:0]             i_rem,
    input  logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::OUT_W-1:0] i_q,
    input  logic [DMW-1:0]                                 i_dmag,
    input  logic                                           i_rdy,
    output logic                                           o_vld,
    output mi3_pkg::t_flags                                o_flags,
    output logic [mi3_pkg::N_ELEM-1:0][CW-1:0]             o_rem,
    output logic [mi3_pkg::N_ELEM-1:0][mi3_pkg::OUT_W-1:0] o_q,
    output logic [DMW-1:0]                                 o_dmag
);
    import mi3_pkg::*;

    logic                         r_vld, en;
    t_flags                       r_flags;
    logic [N_ELEM-1:0][CW-1:0]    r_rem, n_rem;
    logic [N_ELEM-1:0][OUT_W-1:0] r_q, n_q;
    logic [DMW-1:0]               r_dmag;
    logic [CW-1:0]                dsh;
    logic                         ge;

    assign en    = !r_vld || i_rdy;
    assign o_rdy = en;
    assign dsh   = CW'(i_dmag) << BIT;

    always_comb begin
        ge = 1'b0;
        for (int j = 0; j < N_ELEM; j++) begin
            ge       = i_rem[j] >= dsh;
            n_rem[j] = ge ? i_rem[j] - dsh : i_rem[j];
            n_q[j]   = i_q[j];
            n_q[j][BIT] = ge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_flags <= i_flags;
            r_rem   <= n_rem;
            r_q     <= n_q;
            r_dmag  <= i_dmag;
        end
    end

    assign o_vld   = r_vld;
    assign o_flags = r_flags;
    assign o_rem   = r_rem;
    assign o_q     = r_q;
    assign o_dmag  = r_dmag;

endmodule

@@ tb/matrix_inverse_3x3_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for matrix_inverse_3x3: random and directed matrices,
// expected inverse computed in wide integer arithmetic; depends on mi3_pkg and the rtl
module matrix_inverse_3x3_tb;
    import mi3_pkg::*;

    localparam int EW = 16;
    localparam int FB = 8;
    localparam int DW = ((9*EW+7)/8)*8;
    localparam int LATENCY = 39;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [9*OUT_W-1:0] inv;
        logic               singular;
        logic               saturated;
    } t_inv_result;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_s_tvalid = 1'b0;
    logic             o_s_tready;
    logic [DW-1:0]    i_s_tdata = '0;
    logic             o_m_tvalid;
    logic             i_m_tready = 1'b0;
    logic [9*OUT_W-1:0] o_m_tdata;
    logic [1:0]       o_m_tuser;

    matrix_inverse_3x3 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser)
    );

    logic [DW-1:0] pending_mats[$];
    t_inv_result   expected_invs[$];
    int            errors = 0;
    int            n_singular = 0;
    int            n_saturated = 0;
    int            n_checked = 0;
    int            send_gap = 0;
    int            recv_gap = 0;
    bit            no_idle = 1'b0;
    bit            hold_send = 1'b0;
    longint        cycles = 0;

    // handshake seen at the last rising edge
    logic o_s_tready_q = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_inv_result compute_inverse(logic [DW-1:0] mat);
        logic signed [127:0] m[9];
        logic signed [127:0] adj[9];
        logic signed [127:0] det;
        logic [127:0] dmag, num, q;
        logic [31:0] mag;
        logic neg;
        t_inv_result r;
        r = '0;
        for (int i = 0; i < 9; i++)
            m[i] = 128'(signed'(mat[i*EW +: EW]));
        adj[0] = m[4]*m[8] - m[5]*m[7];
        adj[1] = m[2]*m[7] - m[1]*m[8];
        adj[2] = m[1]*m[5] - m[2]*m[4];
        adj[3] = m[5]*m[6] - m[3]*m[8];
        adj[4] = m[0]*m[8] - m[2]*m[6];
        adj[5] = m[2]*m[3] - m[0]*m[5];
        adj[6] = m[3]*m[7] - m[4]*m[6];
        adj[7] = m[1]*m[6] - m[0]*m[7];
        adj[8] = m[0]*m[4] - m[1]*m[3];
        det = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        dmag = det[127] ? -det : det;
        for (int i = 0; i < 9; i++) begin
            neg = adj[i][127] != det[127];
            num = (adj[i][127] ? -adj[i] : adj[i]) << (FB + OUT_FRAC);
            q = num / dmag;
            if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF)) begin
                mag = neg ? NEG_LIM : POS_LIM;
                r.saturated = 1'b1;
            end else begin
                mag = q[31:0];
            end
            r.inv[i*OUT_W +: OUT_W] = neg ? -mag : mag;
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] pack_mat(logic [15:0] e[9]);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++)
            d[i*EW +: EW] = e[i];
        return d;
    endfunction

    function automatic logic [15:0] rand_elem(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 6) - 3) << 8;
            2: return 16'($urandom_range(0, 8) - 4);
            default: return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
        endcase
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready_q) begin
                expected_invs.push_back(compute_inverse(i_s_tdata));
                void'(pending_mats.pop_front());
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end
            if (!hold_send && pending_mats.size() > 0 && send_gap == 0 &&
                !(i_s_tvalid && !o_s_tready_q && 1'b0)) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_mats[0];
                if (!no_idle && $urandom_range(0, 19) == 0)
                    send_gap <= $urandom_range(1, 14);
            end else if (!(i_s_tvalid && !o_s_tready_q)) begin
                i_s_tvalid <= 1'b0;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 19) == 0) begin
                recv_gap <= $urandom_range(1, 14);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        o_s_tready_q <= i_s_tvalid && o_s_tready;
    end

    // monitor
    always @(posedge i_clk) begin
        t_inv_result got, want;
        cycles <= cycles + 1;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.inv = o_m_tdata;
            got.singular = o_m_tuser[0];
            got.saturated = o_m_tuser[1];
            if (expected_invs.size() == 0) begin
                $display("%0t: unexpected item tdata=%h tuser=%b", $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = expected_invs.pop_front();
                n_checked++;
                if (want.singular) n_singular++;
                if (want.saturated) n_saturated++;
                for (int i = 0; i < 9; i++)
                    if (got.inv[i*OUT_W +: OUT_W] !== want.inv[i*OUT_W +: OUT_W]) begin
                        $display("%0t: inv element %0d expected %h actual %h", $time, i,
                                 want.inv[i*OUT_W +: OUT_W], got.inv[i*OUT_W +: OUT_W]);
                        errors++;
                    end
                if (got.singular !== want.singular || got.saturated !== want.saturated) begin
                    $display("%0t: flags expected sing=%b sat=%b actual sing=%b sat=%b",
                             $time, want.singular, want.saturated,
                             got.singular, got.saturated);
                    errors++;
                end
            end
        end
    end

    initial begin
        logic [15:0] e[9];
        int mode;
        // identity, singular, extremes, scaled identity
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h0100 : 16'h0000;
        pending_mats.push_back(pack_mat(e));
        pending_mats.push_back('0);
        for (int i = 0; i < 9; i++) e[i] = 16'h7FFF;
        pending_mats.push_back(pack_mat(e));
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h8000 : 16'h0000;
        pending_mats.push_back(pack_mat(e));
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h7FFF : 16'h0000;
        pending_mats.push_back(pack_mat(e));
        // tiny diagonal, large inverse
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h0001 : 16'h0000;
        pending_mats.push_back(pack_mat(e));
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'hFFFF : 16'h0000;
        pending_mats.push_back(pack_mat(e));
        // negative diagonal
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'hFF80 : 16'h0000;
        pending_mats.push_back(pack_mat(e));
        // upper triangle whose inv12 lands exactly on -2^31, then on +2^31 (clamped)
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? 16'h0001 : 16'h0000;
        e[1] = 16'h0080;
        pending_mats.push_back(pack_mat(e));
        e[1] = 16'hFF80;
        pending_mats.push_back(pack_mat(e));
        for (int i = 0; i < 9; i++) e[i] = 16'(i + 1) << 8;
        pending_mats.push_back(pack_mat(e));
        for (int i = 0; i < 9; i++) e[i] = {16{i[0]}};
        pending_mats.push_back(pack_mat(e));
        for (int i = 0; i < 9; i++) e[i] = {16{~i[0]}};
        pending_mats.push_back(pack_mat(e));
        for (int n = 0; n < 1800; n++) begin
            mode = $urandom_range(0, 9);
            mode = (mode < 5) ? 0 : (mode < 8) ? 1 : (mode < 9) ? 2 : 3;
            for (int i = 0; i < 9; i++) e[i] = rand_elem(mode);
            // some rows copied to force singular matrices
            if ($urandom_range(0, 15) == 0)
                for (int i = 0; i < 3; i++) e[6+i] = e[i];
            pending_mats.push_back(pack_mat(e));
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // pause once mid-run until the pipeline drains
        wait (pending_mats.size() < 1200);
        hold_send = 1'b1;
        wait (expected_invs.size() == 0 && !i_s_tvalid);
        hold_send = 1'b0;
        wait (pending_mats.size() < 300);
        no_idle = 1'b1;
        wait (pending_mats.size() == 0 && !i_s_tvalid && expected_invs.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("checked %0d inverses: %0d singular, %0d saturated", n_checked,
                 n_singular, n_saturated);
        if (errors == 0)
            $display("PASS matrix_inverse_3x3");
        else
            $display("FAIL matrix_inverse_3x3");
        $finish;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycles);
        $display("FAIL matrix_inverse_3x3");
        $finish;
    end
endmodule

@@ matrix_inverse_3x3.f @@
hw/rtl/mi3_pkg.sv
hw/rtl/mi3_adj.sv
hw/rtl/mi3_det.sv
hw/rtl/mi3_div_stage.sv
hw/rtl/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_tb.sv
